// ===== src/multicast_group_hash_table_assert.svh =====
// Assertion macros used by the checker file mcght_checker.sv.
`ifndef MULTICAST_GROUP_HASH_TABLE_ASSERT_SVH
`define MULTICAST_GROUP_HASH_TABLE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define MCGHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle property");

// The consequent must hold in the same cycle as the antecedent.
`define MCGHT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle property");

`endif

// ===== src/mcght_pkg.sv =====
`default_nettype none
package mcght_pkg;

  localparam int HASH_ENTRIES      = 256;
  localparam int OVERFLOW_ENTRIES  = 256;
  localparam int MEMBERS_PER_ENTRY = 8;
  localparam int TABLE_ENTRIES     = HASH_ENTRIES + OVERFLOW_ENTRIES;
  localparam int ENTRY_W           = 9;
  localparam int OVF_W             = 8;
  localparam int SLOT_W            = 3;
  localparam int MEM_ADDR_W        = ENTRY_W + SLOT_W;
  localparam int SLOT_DATA_W       = 25;
  localparam int GID_W             = 128;
  localparam int STEPS_W           = 10;

  typedef enum logic [2:0] {
    STS_OK             = 3'd0,
    STS_ALREADY        = 3'd1,
    STS_NO_FREE        = 3'd2,
    STS_FULL           = 3'd3,
    STS_GROUP_MISSING  = 3'd4,
    STS_MEMBER_MISSING = 3'd5,
    STS_CORRUPT        = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WRD, S_WCHK, S_MRD, S_MCHK, S_AWR, S_ORD, S_OCHK,
    S_OWR, S_DMOVE, S_DZERO, S_PRD, S_PWR, S_CPY, S_UNLINK, S_HCLR, S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/multicast_group_hash_table.sv =====
`default_nettype none
// Multicast group table. Each input beat attaches (in_tuser 0) or detaches
// (in_tuser 1) a member number to or from a 128-bit group id, starting at a
// precomputed hash slot. Each command produces exactly one result beat with
// a status code and, on OK or ALREADY, the table entry that holds the group.
// After reset the block clears its stores, one member slot per cycle, over all
// 4096 member slots; in_tready stays low during that pass.
// One command is in work at a time. A command is accepted, then reads and
// checks each chain entry walked and each member slot scanned, and last
// hands its result to the output register. On top of that, an attach
// stores the member in place, or reads and checks overflow flags and then
// writes each member slot of a new overflow entry; a detach moves and clears
// a member, then unlinks an emptied entry or clears an emptied head, or pulls
// a successor into an emptied head. The worst case is bounded by the chain
// length and the 256 overflow flags. Every store is a single-port-write RAM
// with a registered read, and each step of the walk waits for one read.
// The result sits in an output register; the block takes the next command
// while it waits, and holds a finished second result until out_tready
// frees the register.
module multicast_group_hash_table (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // gid_high[63:0], gid_low[127:64], hash_index[135:128], member_number[159:136]
  input  wire logic [159:0] in_tdata,
  // cmd[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[2:0], entry_index[11:3], zero[15:12]
  output logic      [15:0]  out_tdata
);

  import mcght_pkg::*;

  state_t state_r, state_nxt;
  logic [MEM_ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic                   cmd_r, cmd_nxt;
  logic [GID_W-1:0]       gid_r, gid_nxt;
  logic [ENTRY_W-1:0]     head_r, head_nxt;
  logic [SLOT_DATA_W-1:0] want_r, want_nxt;
  logic [ENTRY_W-1:0]     cur_r, cur_nxt;
  logic [ENTRY_W-1:0]     prev_r, prev_nxt;
  logic                   has_prev_r, has_prev_nxt;
  logic [STEPS_W-1:0]     steps_r, steps_nxt;
  logic [ENTRY_W-1:0]     link_r, link_nxt;
  logic [SLOT_W:0]        slot_r, slot_nxt;
  logic [SLOT_W-1:0]      loc_r, loc_nxt;
  logic                   seen_r, seen_nxt;
  logic [SLOT_DATA_W-1:0] last_r, last_nxt;
  logic [ENTRY_W-1:0]     newe_r, newe_nxt;
  status_t                status_r, status_nxt;
  logic [ENTRY_W-1:0]     result_r, result_nxt;
  logic                   out_valid_r;
  logic [15:0]            out_data_r;

  logic                   gid_we, link_we, mem_we, ovf_we;
  logic [ENTRY_W-1:0]     gid_waddr, link_waddr, ent_raddr;
  logic [GID_W-1:0]       gid_wdata, gid_rd;
  logic [ENTRY_W-1:0]     link_wdata, link_rd;
  logic [MEM_ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [SLOT_DATA_W-1:0] mem_wdata, mem_rd;
  logic [OVF_W-1:0]       ovf_waddr, ovf_raddr;
  logic                   ovf_wdata, ovf_rd;

  logic in_gid_zero, gid_empty, gid_hit, walk_corrupt, walk_found, walk_end;
  logic slot_hit, slot_valid, last_slot, scan_done, seen_now, out_free;

  mcght_ram #(.WIDTH(GID_W), .DEPTH(TABLE_ENTRIES)) u_gid_ram (
    .clk(clk), .we(gid_we), .waddr(gid_waddr), .wdata(gid_wdata),
    .raddr(ent_raddr), .rdata(gid_rd)
  );

  mcght_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(ent_raddr), .rdata(link_rd)
  );

  mcght_ram #(.WIDTH(SLOT_DATA_W), .DEPTH(TABLE_ENTRIES * MEMBERS_PER_ENTRY)) u_mem_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rd)
  );

  mcght_ram #(.WIDTH(1), .DEPTH(OVERFLOW_ENTRIES)) u_ovf_ram (
    .clk(clk), .we(ovf_we), .waddr(ovf_waddr), .wdata(ovf_wdata),
    .raddr(ovf_raddr), .rdata(ovf_rd)
  );

  assign in_gid_zero  = (in_tdata[127:0] == '0);
  assign gid_empty    = (gid_rd == '0);
  assign gid_hit      = (gid_rd == gid_r);
  assign walk_corrupt = (steps_r > STEPS_W'(TABLE_ENTRIES)) || (gid_empty && cur_r != head_r);
  assign walk_found   = !walk_corrupt && (gid_empty || gid_hit);
  assign walk_end     = !walk_corrupt && !walk_found && (link_rd == '0);
  assign slot_hit     = (mem_rd == want_r);
  assign slot_valid   = mem_rd[SLOT_DATA_W-1];
  assign last_slot    = (slot_r == (SLOT_W+1)'(MEMBERS_PER_ENTRY - 1));
  assign scan_done    = !slot_valid || last_slot;
  assign seen_now     = seen_r || slot_hit;
  assign out_free     = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (cnt_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_gid_zero ? S_DONE : S_WRD;
        end
      end
      S_WRD: state_nxt = S_WCHK;
      S_WCHK: begin
        if (walk_corrupt) begin
          state_nxt = S_DONE;
        end else if (walk_found) begin
          state_nxt = S_MRD;
        end else if (walk_end) begin
          state_nxt = cmd_r ? S_DONE : S_ORD;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_MRD: state_nxt = S_MCHK;
      S_MCHK: begin
        if (!cmd_r) begin
          if (slot_hit) begin
            state_nxt = S_DONE;
          end else if (!slot_valid) begin
            state_nxt = S_AWR;
          end else if (last_slot) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MRD;
          end
        end else if (scan_done) begin
          state_nxt = seen_now ? S_DMOVE : S_DONE;
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_AWR: state_nxt = S_DONE;
      S_ORD: state_nxt = S_OCHK;
      S_OCHK: begin
        if (!ovf_rd) begin
          state_nxt = S_OWR;
        end else if (cnt_r[OVF_W-1:0] == '1) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ORD;
        end
      end
      S_OWR: if (cnt_r[SLOT_W-1:0] == '1) state_nxt = S_DONE;
      S_DMOVE: state_nxt = S_DZERO;
      S_DZERO: begin
        if (slot_r != (SLOT_W+1)'(1)) begin
          state_nxt = S_DONE;
        end else if (has_prev_r) begin
          state_nxt = S_UNLINK;
        end else begin
          state_nxt = (link_r != '0) ? S_PRD : S_HCLR;
        end
      end
      S_PRD: state_nxt = S_PWR;
      S_PWR: state_nxt = S_CPY;
      S_CPY: if (cnt_r[SLOT_W:0] == (SLOT_W+1)'(MEMBERS_PER_ENTRY)) state_nxt = S_DONE;
      S_UNLINK: state_nxt = S_DONE;
      S_HCLR: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    gid_nxt      = gid_r;
    head_nxt     = head_r;
    want_nxt     = want_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    has_prev_nxt = has_prev_r;
    steps_nxt    = steps_r;
    link_nxt     = link_r;
    slot_nxt     = slot_r;
    loc_nxt      = loc_r;
    seen_nxt     = seen_r;
    last_nxt     = last_r;
    newe_nxt     = newe_r;
    status_nxt   = status_r;
    result_nxt   = result_r;
    gid_we       = 1'b0;
    gid_waddr    = cur_r;
    gid_wdata    = gid_r;
    link_we      = 1'b0;
    link_waddr   = cur_r;
    link_wdata   = '0;
    mem_we       = 1'b0;
    mem_waddr    = {cur_r, slot_r[SLOT_W-1:0]};
    mem_wdata    = '0;
    ovf_we       = 1'b0;
    ovf_waddr    = cnt_r[OVF_W-1:0];
    ovf_wdata    = 1'b0;
    ent_raddr    = cur_r;
    mem_raddr    = {cur_r, slot_r[SLOT_W-1:0]};
    ovf_raddr    = cnt_r[OVF_W-1:0];
    case (state_r)
      S_CLEAR: begin
        gid_we     = 1'b1;
        gid_waddr  = cnt_r[ENTRY_W-1:0];
        gid_wdata  = '0;
        link_we    = 1'b1;
        link_waddr = cnt_r[ENTRY_W-1:0];
        mem_we     = 1'b1;
        mem_waddr  = cnt_r;
        ovf_we     = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
      end
      S_IDLE: begin
        cmd_nxt      = in_tuser;
        gid_nxt      = {in_tdata[63:0], in_tdata[127:64]};
        head_nxt     = {1'b0, in_tdata[135:128]};
        cur_nxt      = {1'b0, in_tdata[135:128]};
        want_nxt     = {1'b1, in_tdata[159:136]};
        has_prev_nxt = 1'b0;
        prev_nxt     = '0;
        steps_nxt    = '0;
        slot_nxt     = '0;
        seen_nxt     = 1'b0;
        cnt_nxt      = '0;
        result_nxt   = '0;
        status_nxt   = in_gid_zero ? STS_GROUP_MISSING : STS_OK;
      end
      S_WCHK: begin
        steps_nxt = steps_r + 1'b1;
        link_nxt  = link_rd;
        if (walk_corrupt) begin
          status_nxt = STS_CORRUPT;
        end else if (!walk_found) begin
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt      = link_rd;
          if (walk_end && cmd_r) begin
            status_nxt = STS_GROUP_MISSING;
          end
        end
      end
      S_MCHK: begin
        if (!cmd_r) begin
          if (slot_hit) begin
            status_nxt = STS_ALREADY;
            result_nxt = cur_r;
          end else if (slot_valid) begin
            slot_nxt = slot_r + 1'b1;
            if (last_slot) begin
              status_nxt = STS_FULL;
            end
          end
        end else begin
          if (slot_hit) begin
            loc_nxt  = slot_r[SLOT_W-1:0];
            seen_nxt = 1'b1;
          end
          if (slot_valid) begin
            last_nxt = mem_rd;
            slot_nxt = slot_r + 1'b1;
          end
          if (scan_done && !seen_now) begin
            status_nxt = STS_MEMBER_MISSING;
          end
        end
      end
      S_AWR: begin
        mem_we     = 1'b1;
        mem_wdata  = want_r;
        gid_we     = 1'b1;
        result_nxt = cur_r;
      end
      S_OCHK: begin
        if (!ovf_rd) begin
          newe_nxt = {1'b1, cnt_r[OVF_W-1:0]};
          cnt_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r[OVF_W-1:0] == '1) begin
            status_nxt = STS_NO_FREE;
          end
        end
      end
      S_OWR: begin
        mem_we    = 1'b1;
        mem_waddr = {newe_r, cnt_r[SLOT_W-1:0]};
        mem_wdata = (cnt_r[SLOT_W-1:0] == '0) ? want_r : '0;
        if (cnt_r[SLOT_W-1:0] == '0) begin
          gid_we     = 1'b1;
          gid_waddr  = newe_r;
          link_we    = 1'b1;
          link_waddr = newe_r;
          ovf_we     = 1'b1;
          ovf_waddr  = newe_r[OVF_W-1:0];
          ovf_wdata  = 1'b1;
        end else if (cnt_r[SLOT_W-1:0] == SLOT_W'(1)) begin
          link_we    = 1'b1;
          link_waddr = prev_r;
          link_wdata = newe_r;
        end
        cnt_nxt    = cnt_r + 1'b1;
        result_nxt = newe_r;
      end
      S_DMOVE: begin
        mem_we     = 1'b1;
        mem_waddr  = {cur_r, loc_r};
        mem_wdata  = last_r;
        result_nxt = cur_r;
      end
      S_DZERO: begin
        mem_we    = 1'b1;
        mem_waddr = {cur_r, SLOT_W'(slot_r - 1'b1)};
        cnt_nxt   = '0;
      end
      S_PRD: ent_raddr = link_r;
      S_PWR: begin
        gid_we     = 1'b1;
        gid_wdata  = gid_rd;
        link_we    = 1'b1;
        link_wdata = link_rd;
        ovf_we     = link_r[ENTRY_W-1];
        ovf_waddr  = link_r[OVF_W-1:0];
      end
      S_CPY: begin
        mem_raddr = {link_r, cnt_r[SLOT_W-1:0]};
        mem_we    = (cnt_r[SLOT_W:0] != '0);
        mem_waddr = {cur_r, SLOT_W'(cnt_r[SLOT_W:0] - 1'b1)};
        mem_wdata = mem_rd;
        cnt_nxt   = cnt_r + 1'b1;
      end
      S_UNLINK: begin
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = link_r;
        ovf_we     = cur_r[ENTRY_W-1];
        ovf_waddr  = cur_r[OVF_W-1:0];
      end
      S_HCLR: begin
        gid_we    = 1'b1;
        gid_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    gid_r      <= gid_nxt;
    head_r     <= head_nxt;
    want_r     <= want_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    has_prev_r <= has_prev_nxt;
    steps_r    <= steps_nxt;
    link_r     <= link_nxt;
    slot_r     <= slot_nxt;
    loc_r      <= loc_nxt;
    seen_r     <= seen_nxt;
    last_r     <= last_nxt;
    newe_r     <= newe_nxt;
    status_r   <= status_nxt;
    result_r   <= result_nxt;
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {4'b0000,
                     (status_r == STS_OK || status_r == STS_ALREADY) ?
                       result_r : {ENTRY_W{1'b0}},
                     status_r};
    end
  end

endmodule
`default_nettype wire

// ===== src/mcght_ram.sv =====
`default_nettype none
module mcght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== src/mcght_checker.sv =====
`default_nettype none
`include "multicast_group_hash_table_assert.svh"
module mcght_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  import mcght_pkg::*;

  `MCGHT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `MCGHT_ASSERT_NEXT(a_one_in_work, in_tvalid && in_tready, !in_tready)
  `MCGHT_ASSERT_NOW(a_err_zero_entry, out_tvalid && out_tdata[2:0] != STS_OK && out_tdata[2:0] != STS_ALREADY, out_tdata[11:3] == 9'd0)
  `MCGHT_ASSERT_NOW(a_status_code, out_tvalid, out_tdata[2:0] != 3'd7 && out_tdata[15:12] == 4'd0)

endmodule

bind multicast_group_hash_table mcght_checker u_mcght_checker (.*);
`default_nettype wire

// ===== bench/multicast_group_hash_table_tb.sv =====
module multicast_group_hash_table_tb;
  import mcght_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;

  typedef struct {
    logic         cmd;
    logic [63:0]  gid_hi;
    logic [63:0]  gid_lo;
    logic [7:0]   hash;
    logic [23:0]  member;
    logic         typed;
    status_t      sts;
    logic [8:0]   entry;
  } op_t;

  typedef struct {
    status_t    sts;
    logic [8:0] entry;
  } reply_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;

  logic [63:0] grp_hi [TABLE_ENTRIES];
  logic [63:0] grp_lo [TABLE_ENTRIES];
  logic [8:0]  link [TABLE_ENTRIES];
  logic [24:0] slot [TABLE_ENTRIES * MEMBERS_PER_ENTRY];
  logic        ovf_busy [OVERFLOW_ENTRIES];

  reply_t pending_replies[$];
  op_t    directed_ops[$];
  int     errors;
  int     cycles;
  bit     quiet_out;
  bit     hold_out;
  bit     busy_in;
  bit     stim_done;

  logic [63:0] pool_hi [8];
  logic [63:0] pool_lo [8];
  logic [7:0]  pool_hash [8];

  multicast_group_hash_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic reply_t table_apply(input op_t op);
    reply_t r;
    logic [8:0] head, e, idx, prv, nx;
    bit has_prv;
    int wres, steps, i, k, loc, base;
    bit seen;
    logic [24:0] want;
    head = {1'b0, op.hash};
    want = {1'b1, op.member};
    r.sts = STS_OK;
    r.entry = '0;
    idx = 0;
    prv = 0;
    has_prv = 0;
    wres = 0;
    if (op.gid_hi == 0 && op.gid_lo == 0) begin
      r.sts = STS_GROUP_MISSING;
      return r;
    end
    e = head;
    steps = 0;
    forever begin
      if (steps > TABLE_ENTRIES) begin
        wres = 2;
        break;
      end
      steps++;
      if (grp_hi[e] == 0 && grp_lo[e] == 0) begin
        wres = (e != head) ? 2 : 0;
        idx = e;
        break;
      end
      if (grp_hi[e] == op.gid_hi && grp_lo[e] == op.gid_lo) begin
        idx = e;
        wres = 0;
        break;
      end
      prv = e;
      has_prv = 1;
      e = link[e];
      if (e == 0) begin
        wres = 1;
        break;
      end
    end
    if (wres == 2) begin
      r.sts = STS_CORRUPT;
      return r;
    end
    base = idx * MEMBERS_PER_ENTRY;
    if (op.cmd == 1'b0) begin
      if (wres == 0) begin
        for (i = 0; i < MEMBERS_PER_ENTRY; i++) begin
          if (slot[base + i] == want) begin
            r.sts = STS_ALREADY;
            r.entry = idx;
            return r;
          end
          if (!slot[base + i][24]) break;
        end
        if (i == MEMBERS_PER_ENTRY) begin
          r.sts = STS_FULL;
        end else begin
          slot[base + i] = want;
          grp_hi[idx] = op.gid_hi;
          grp_lo[idx] = op.gid_lo;
          r.entry = idx;
        end
      end else begin
        for (k = 0; k < OVERFLOW_ENTRIES; k++)
          if (!ovf_busy[k]) break;
        if (k == OVERFLOW_ENTRIES) begin
          r.sts = STS_NO_FREE;
        end else begin
          e = HASH_ENTRIES + k;
          ovf_busy[k] = 1;
          for (i = 0; i < MEMBERS_PER_ENTRY; i++) slot[e * MEMBERS_PER_ENTRY + i] = '0;
          slot[e * MEMBERS_PER_ENTRY] = want;
          grp_hi[e] = op.gid_hi;
          grp_lo[e] = op.gid_lo;
          link[e] = 0;
          link[prv] = e;
          r.entry = e;
        end
      end
    end else if (wres == 1) begin
      r.sts = STS_GROUP_MISSING;
    end else begin
      seen = 0;
      loc = 0;
      for (i = 0; i < MEMBERS_PER_ENTRY; i++) begin
        if (slot[base + i] == want) begin
          loc = i;
          seen = 1;
        end
        if (!slot[base + i][24]) break;
      end
      if (!seen) begin
        r.sts = STS_MEMBER_MISSING;
      end else begin
        slot[base + loc] = slot[base + i - 1];
        slot[base + i - 1] = '0;
        r.entry = idx;
        if (i == 1) begin
          if (!has_prv) begin
            nx = link[idx];
            if (nx != 0) begin
              grp_hi[idx] = grp_hi[nx];
              grp_lo[idx] = grp_lo[nx];
              link[idx] = link[nx];
              for (k = 0; k < MEMBERS_PER_ENTRY; k++)
                slot[base + k] = slot[nx * MEMBERS_PER_ENTRY + k];
              if (nx >= HASH_ENTRIES) ovf_busy[nx - HASH_ENTRIES] = 0;
            end else begin
              grp_hi[idx] = 0;
              grp_lo[idx] = 0;
            end
          end else begin
            link[prv] = link[idx];
            if (idx >= HASH_ENTRIES) ovf_busy[idx - HASH_ENTRIES] = 0;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_op(input op_t op);
    reply_t r;
    r = table_apply(op);
    if (op.typed && (r.sts != op.sts || r.entry != op.entry))
      report($sformatf("directed row expects sts %0d entry %0d, predictor %0d %0d",
                       op.sts, op.entry, r.sts, r.entry));
    while (busy_in && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op.cmd;
    in_tdata <= {op.member, op.hash, op.gid_lo, op.gid_hi};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_replies.push_back(r);
  endtask

  function automatic op_t mk(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
                             input logic [7:0] h, input logic [23:0] m);
    op_t op;
    op.cmd = cmd;
    op.gid_hi = hi;
    op.gid_lo = lo;
    op.hash = h;
    op.member = m;
    op.typed = 0;
    op.sts = STS_OK;
    op.entry = '0;
    return op;
  endfunction

  function automatic op_t mkx(input op_t op, input status_t s, input logic [8:0] e);
    op_t o;
    o = op;
    o.typed = 1;
    o.sts = s;
    o.entry = e;
    return o;
  endfunction

  function automatic op_t rand_op();
    int p;
    logic [23:0] m;
    p = $urandom_range(7);
    m = ($urandom_range(99) < 85) ? 24'($urandom_range(15)) : 24'($urandom);
    if ($urandom_range(99) < 90)
      return mk($urandom_range(99) < 45, pool_hi[p], pool_lo[p], pool_hash[p], m);
    return mk($urandom_range(1), {$urandom, $urandom}, {$urandom, $urandom},
              8'($urandom), 24'($urandom));
  endfunction

  // Receiver: random stalls, a calm stretch and one long hold-off.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      out_tready <= hold_out ? 1'b0 : (quiet_out ? 1'b1 : ($urandom_range(99) >= 31));
    end
  end

  initial begin
    reply_t want;
    reply_t got;
    errors = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got.sts = status_t'(out_tdata[2:0]);
        got.entry = out_tdata[11:3];
        if (pending_replies.size() == 0) begin
          report($sformatf("unexpected result beat %h", out_tdata));
        end else begin
          want = pending_replies.pop_front();
          if (got.sts != want.sts)
            report($sformatf("status %0d, expected %0d", got.sts, want.sts));
          if (got.entry != want.entry)
            report($sformatf("entry %0d, expected %0d", got.entry, want.entry));
          if (out_tdata[15:12] != 0) report("padding bits set");
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("multicast_group_hash_table_tb failed");
        $finish;
      end
    end
  end

  initial begin
    op_t g;
    op_t h;
    int n, i, j;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    quiet_out = 0;
    hold_out = 0;
    busy_in = 1;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      grp_hi[i] = 0;
      grp_lo[i] = 0;
      link[i] = 0;
    end
    for (i = 0; i < TABLE_ENTRIES * MEMBERS_PER_ENTRY; i++) slot[i] = 0;
    for (i = 0; i < OVERFLOW_ENTRIES; i++) ovf_busy[i] = 0;
    for (i = 0; i < 8; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
      pool_hash[i] = (i < 4) ? 8'd7 : 8'($urandom);
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    g = mk(1'b0, '1, '1, 8'hFF, 24'hFFFFFF);
    h = mk(1'b0, 64'h1, 64'h0, 8'hFF, 24'h0);
    directed_ops.push_back(mkx(mk(1'b0, 0, 0, 8'h0, 24'h5), STS_GROUP_MISSING, 0));
    directed_ops.push_back(mkx(mk(1'b1, 0, 0, 8'h3, 24'h5), STS_GROUP_MISSING, 0));
    directed_ops.push_back(mkx(g, STS_OK, 255));
    directed_ops.push_back(mkx(g, STS_ALREADY, 255));
    directed_ops.push_back(mkx(h, STS_OK, 256));
    directed_ops.push_back(mkx(mk(1'b1, 64'h1, 64'h0, 8'hFF, 24'h1), STS_MEMBER_MISSING, 0));
    directed_ops.push_back(mkx(mk(1'b1, 64'h2, 64'h0, 8'hFF, 24'h1), STS_GROUP_MISSING, 0));
    directed_ops.push_back(mkx(mk(1'b1, 64'h9, 64'h9, 8'h10, 24'h1), STS_MEMBER_MISSING, 0));
    for (j = 1; j < MEMBERS_PER_ENTRY; j++)
      directed_ops.push_back(mk(1'b0, '1, '1, 8'hFF, 24'(j)));
    directed_ops.push_back(mkx(mk(1'b0, '1, '1, 8'hFF, 24'h77), STS_FULL, 0));
    directed_ops.push_back(mk(1'b1, '1, '1, 8'hFF, 24'h3));
    g.cmd = 1'b1;
    directed_ops.push_back(g);
    directed_ops.push_back(mk(1'b1, '1, '1, 8'hFF, 24'h1));
    for (j = 2; j < MEMBERS_PER_ENTRY; j++)
      if (j != 3) directed_ops.push_back(mk(1'b1, '1, '1, 8'hFF, 24'(j)));
    h.cmd = 1'b1;
    directed_ops.push_back(h);
    @(posedge clk);
    foreach (directed_ops[i]) send_op(directed_ops[i]);

    // Calm stretch with no idling on either side.
    busy_in = 0;
    quiet_out = 1;
    for (n = 0; n < 60; n++) send_op(rand_op());
    busy_in = 1;
    quiet_out = 0;

    // Long receiver hold-off while commands keep coming.
    fork
      begin
        hold_out = 1;
        repeat (400) @(posedge clk);
        hold_out = 0;
      end
      for (n = 0; n < 20; n++) send_op(rand_op());
    join

    // Sender pauses until every result is back.
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);

    // Fill the overflow area to reach its exhaustion.
    for (n = 0; n < OVERFLOW_ENTRIES + 2; n++)
      send_op(mk(1'b0, {32'h0, 32'($urandom)}, 64'(n + 1), 8'd200, 24'($urandom)));

    for (n = 0; n < 40; n++) send_op(rand_op());
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("multicast_group_hash_table_tb passed");
    end else begin
      $display("multicast_group_hash_table_tb failed");
    end
    $finish;
  end

endmodule
